[design/lrp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared constants and types for the lru page replacement block.
// ----------------------------------------------------------------------------
package lrp_pkg;

  localparam int FRAMES    = 3;
  localparam int PAGE_BITS = 8;
  localparam int IDX_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_BITS = IDX_BITS;

  localparam logic [RANK_BITS-1:0] RANK_OLDEST = RANK_BITS'(FRAMES - 1);

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [RANK_BITS-1:0] rank_t;

  // search results rippled along the row of cells
  typedef struct packed {
    logic  hit_found;
    idx_t  hit_idx;
    rank_t hit_rank;
    logic  empty_found;
    idx_t  empty_idx;
    logic  lru_found;
    idx_t  lru_idx;
    page_t lru_page;
  } chain_t;

  // update broadcast to every cell
  typedef struct packed {
    logic  en;
    idx_t  slot;
    logic  miss;
    rank_t limit;
    page_t page;
  } upd_t;

endpackage

[design/lrp_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_cell
// One frame: page, valid mark and recency rank, with its part of the search.
// ----------------------------------------------------------------------------
module lrp_cell import lrp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  idx_t   cell_idx,
  input  page_t  lookup_page,
  input  chain_t chain_in,
  output chain_t chain_out,
  input  upd_t   upd
);

  page_t page_r;
  logic  valid_r;
  rank_t rank_r;
  logic  match;

  assign match = valid_r && (page_r == lookup_page);

  always_comb begin
    chain_out = chain_in;
    if (!chain_in.hit_found && match) begin
      chain_out.hit_found = 1'b1;
      chain_out.hit_idx   = cell_idx;
      chain_out.hit_rank  = rank_r;
    end
    if (!chain_in.empty_found && !valid_r) begin
      chain_out.empty_found = 1'b1;
      chain_out.empty_idx   = cell_idx;
    end
    // when all frames are full the oldest one holds the top rank
    if (!chain_in.lru_found && valid_r && (rank_r == RANK_OLDEST)) begin
      chain_out.lru_found = 1'b1;
      chain_out.lru_idx   = cell_idx;
      chain_out.lru_page  = page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (upd.en) begin
      if (upd.slot == cell_idx) begin
        valid_r <= 1'b1;
        rank_r  <= '0;
      end else if (valid_r && (upd.miss || (rank_r < upd.limit))) begin
        rank_r <= rank_r + rank_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.miss && (upd.slot == cell_idx)) begin
      page_r <= upd.page;
    end
  end

endmodule

[design/lru_page_replacement.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// Least recently used page replacement over a row of frame cells.
// ----------------------------------------------------------------------------
// usage:
//  - input channel in_valid / in_stall carries one page reference per
//    transaction in in_page_number
//  - result channel out_valid / out_stall returns one transaction per
//    reference: hit, frame slot, evicted page and saturating fault total
//  - every frame cell compares the reference at once; search results ripple
//    along the row of cells and the update is broadcast back the same cycle
//  - the result is registered; out_valid rises in the cycle after acceptance
//  - throughput is one reference per cycle while the output is not stalled;
//    the single result register sets that figure
//  - when the receiver stalls, the result holds and in_stall rises until
//    the result is taken
//  - a synchronous reset (rst_n low) empties all frames and clears the
//    fault total; no result is pending afterwards
// ----------------------------------------------------------------------------
module lru_page_replacement import lrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_page_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [3:0]  out_frame_slot,
  output logic        out_evicted_valid,
  output logic [7:0]  out_evicted_page,
  output logic [31:0] out_fault_total
);

  chain_t chain [FRAMES+1];
  upd_t   upd;
  page_t  page;
  logic   accept;
  logic   hit;
  logic   evict;
  idx_t   slot;

  logic        out_valid_r;
  logic        hit_r;
  idx_t        slot_r;
  logic        evict_r;
  page_t       evict_page_r;
  logic [31:0] fault_count_r;
  logic [31:0] fault_count_nxt;

  assign page     = page_t'(in_page_number);
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign chain[0] = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lrp_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (idx_t'(i)),
      .lookup_page (page),
      .chain_in    (chain[i]),
      .chain_out   (chain[i+1]),
      .upd         (upd)
    );
  end

  always_comb begin
    hit   = chain[FRAMES].hit_found;
    evict = 1'b0;
    if (hit) begin
      slot = chain[FRAMES].hit_idx;
    end else if (chain[FRAMES].empty_found) begin
      slot = chain[FRAMES].empty_idx;
    end else begin
      slot  = chain[FRAMES].lru_idx;
      evict = 1'b1;
    end
    upd.en    = accept;
    upd.slot  = slot;
    upd.miss  = !hit;
    upd.limit = chain[FRAMES].hit_rank;
    upd.page  = page;
  end

  assign fault_count_nxt = (hit || (fault_count_r == '1)) ? fault_count_r
                                                          : fault_count_r + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      fault_count_r <= '0;
    end else if (accept) begin
      out_valid_r   <= 1'b1;
      fault_count_r <= fault_count_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r        <= hit;
      slot_r       <= slot;
      evict_r      <= evict;
      evict_page_r <= evict ? chain[FRAMES].lru_page : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_frame_slot    = 4'(slot_r);
  assign out_evicted_valid = evict_r;
  assign out_evicted_page  = 8'(evict_page_r);
  assign out_fault_total   = fault_count_r;

endmodule
